/* src/mfbs_pkg.sv */
// Shared types, constants and cosine table builder for the block-switched forward MDCT.
`default_nettype none
package mfbs_pkg;

  localparam int LONG_LEN  = 512;
  localparam int LG_LONG   = $clog2(LONG_LEN);
  localparam int SPI       = 4;
  localparam int SAMPLE_W  = 24;
  localparam int COS_W     = 18;
  localparam int COS_FRAC  = COS_W - 1;
  localparam int COEF_W    = 24;
  localparam int COEF_FRAC = 23;
  localparam int IDX_W     = 8;
  localparam int LANES     = 4;

  localparam int PH_W      = LG_LONG + 3;
  localparam int QUARTER   = 2 * LONG_LEN;
  localparam int COS_DEPTH = QUARTER + 1;
  localparam int CADDR_W   = $clog2(COS_DEPTH);
  localparam int ROWS      = LONG_LEN / SPI;
  localparam int ROW_W     = $clog2(ROWS);
  localparam int N_W       = LG_LONG;
  localparam int GRP_W     = LG_LONG - 3;
  localparam int KK_W      = GRP_W + 3;
  localparam int PROD_W    = SAMPLE_W + COS_W;
  localparam int ACC_W     = PROD_W + LG_LONG;
  localparam int FIN_W     = ACC_W + 2;
  localparam int SH_LONG   = COS_FRAC + SAMPLE_W - 1 - COEF_FRAC + LG_LONG - 1;
  localparam int SH_SHORT  = SH_LONG - 1;

  localparam logic [1:0] MODE_LONG   = 2'd0;
  localparam logic [1:0] MODE_SHORT1 = 2'd1;
  localparam logic [1:0] MODE_SHORT2 = 2'd2;

  localparam longint unsigned PI_Q48 = 64'h0003_243F_6A88_85A3;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_0;
    logic signed [SAMPLE_W-1:0] sample_1;
    logic signed [SAMPLE_W-1:0] sample_2;
    logic signed [SAMPLE_W-1:0] sample_3;
  } in_item_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_0;
    logic signed [COEF_W-1:0] coef_1;
    logic signed [COEF_W-1:0] coef_2;
    logic signed [COEF_W-1:0] coef_3;
    logic [IDX_W-1:0]         coef_index;
    logic                     block_done;
  } out_item_t;

  typedef struct packed {
    logic             wr_en;
    logic [ROW_W-1:0] wr_row;
    logic             grp_init;
    logic             issue;
    logic [N_W-1:0]   n;
    logic [GRP_W-1:0] grp;
    logic             load_out;
    logic             last_grp;
    logic [1:0]       mode;
  } mfbs_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } mfbs_sts_t;

  typedef logic [COS_FRAC-1:0] cos_tab_t [COS_DEPTH];

  // Shift-and-subtract quotient, used only while the table is built.
  function automatic longint unsigned udiv64(
    input longint unsigned num,
    input longint unsigned den
  );
    longint unsigned q;
    longint unsigned rem;
    q   = 64'd0;
    rem = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = (rem << 1) | ((num >> b) & 64'd1);
      if (rem >= den) begin
        rem = rem - den;
        q   = q | (64'd1 << b);
      end
    end
    return q;
  endfunction

  // Quarter-wave cosine, Taylor series in Q30, rounded to COS_FRAC bits.
  function automatic cos_tab_t build_cos_table();
    cos_tab_t          t;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint            sum;
    longint            v;
    longint            cmax;
    int                sh;
    cmax = (longint'(1) << COS_FRAC) - 1;
    sh   = 30 - COS_FRAC;
    for (int i = 0; i < COS_DEPTH; i++) begin
      // 4 * LONG_LEN is a power of two
      x    = (((PI_Q48 * longint'(i)) >> (LG_LONG + 2)) + (64'd1 << 17)) >> 18;
      x2   = (x * x + (64'd1 << 29)) >> 30;
      term = 64'd1 << 30;
      sum  = longint'(1) << 30;
      for (int j = 1; j <= 10; j++) begin
        term = (term * x2) >> 30;
        term = udiv64(term, 64'((2 * j - 1) * (2 * j)));
        if ((j & 1) == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      v = (sum + (longint'(1) << (sh - 1))) >>> sh;
      if (v > cmax) v = cmax;
      t[i] = v[COS_FRAC-1:0];
    end
    return t;
  endfunction

endpackage
`default_nettype wire

/* src/mfbs_cos_rom.sv */
// Dual-read quarter-wave cosine ROM with registered outputs.
`default_nettype none
module mfbs_cos_rom
  import mfbs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic [CADDR_W-1:0] addr_a,
  input  wire logic [CADDR_W-1:0] addr_b,
  output logic      [COS_FRAC-1:0] data_a,
  output logic      [COS_FRAC-1:0] data_b
);

  localparam cos_tab_t COS_TAB = build_cos_table();

  logic [COS_FRAC-1:0] data_a_r;
  logic [COS_FRAC-1:0] data_b_r;

  always_ff @(posedge clk) begin
    data_a_r <= COS_TAB[addr_a];
    data_b_r <= COS_TAB[addr_b];
  end

  assign data_a = data_a_r;
  assign data_b = data_b_r;

endmodule
`default_nettype wire

/* src/mfbs_datapath.sv */
// Sample store, four MAC lanes with phase generators, and output register.
`default_nettype none
module mfbs_datapath
  import mfbs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire mfbs_cmd_t cmd,
  input  wire in_item_t  in_data,
  input  wire logic      out_ready,
  output mfbs_sts_t      sts,
  output logic           out_valid,
  output out_item_t      out_data
);

  localparam logic [PH_W:0] Q1 = (PH_W+1)'(QUARTER);
  localparam logic [PH_W:0] Q2 = (PH_W+1)'(2 * QUARTER);
  localparam logic [PH_W:0] Q3 = (PH_W+1)'(3 * QUARTER);
  localparam logic [PH_W:0] Q4 = (PH_W+1)'(4 * QUARTER);
  localparam logic signed [FIN_W-1:0] RND_LONG  = FIN_W'(1) <<< (SH_LONG - 1);
  localparam logic signed [FIN_W-1:0] RND_SHORT = FIN_W'(1) <<< (SH_SHORT - 1);
  localparam logic signed [FIN_W-1:0] SAT_HI = (FIN_W'(1) <<< (COEF_W - 1)) - FIN_W'(1);
  localparam logic signed [FIN_W-1:0] SAT_LO = -(FIN_W'(1) <<< (COEF_W - 1));

  function automatic logic signed [COEF_W-1:0] finish_coef(
    input logic signed [ACC_W-1:0] acc,
    input logic                    short_blk
  );
    logic signed [FIN_W-1:0] neg;
    logic signed [FIN_W-1:0] u;
    logic signed [FIN_W-1:0] r;
    neg = -FIN_W'(acc);
    u   = neg + (short_blk ? RND_SHORT : RND_LONG);
    r   = short_blk ? (u >>> SH_SHORT) : (u >>> SH_LONG);
    if (r > SAT_HI) r = SAT_HI;
    else if (r < SAT_LO) r = SAT_LO;
    return r[COEF_W-1:0];
  endfunction

  // sample store, one row per transaction
  in_item_t store_mem [ROWS];
  in_item_t row_r;

  logic is_short;
  logic [PH_W-1:0] q_r    [LANES];
  logic [PH_W-1:0] step_r [LANES];
  logic [PH_W-1:0] q_nxt    [LANES];
  logic [PH_W-1:0] step_nxt [LANES];

  logic [CADDR_W-1:0] caddr_nxt [LANES];
  logic               neg_nxt   [LANES];
  logic [CADDR_W-1:0] caddr1_r  [LANES];
  logic               neg1_r    [LANES];
  logic [1:0]         sel1_r;
  logic               v1_r;

  logic [COS_FRAC-1:0]        cdat  [LANES];
  logic                       neg2_r [LANES];
  logic signed [SAMPLE_W-1:0] smp2_r;
  logic signed [SAMPLE_W-1:0] smp2_nxt;
  logic                       v2_r;

  logic signed [PROD_W-1:0] prod3_r   [LANES];
  logic signed [PROD_W-1:0] prod3_nxt [LANES];
  logic                     v3_r;

  logic signed [ACC_W-1:0] acc_r [LANES];

  out_item_t out_data_r;
  logic      out_valid_r;
  logic      short_r;

  assign is_short = (cmd.mode == MODE_SHORT1) || (cmd.mode == MODE_SHORT2);

  // Phase start and increment per lane, in units of the long period.
  always_comb begin
    logic [KK_W-1:0] kk;
    logic [2:0]      m3;
    for (int j = 0; j < LANES; j++) begin
      kk = {cmd.grp, 2'(j), 1'b1};
      case (cmd.mode)
        MODE_SHORT1: m3 = 3'd0;
        MODE_SHORT2: m3 = {kk[1:0], 1'b0};
        default:     m3 = kk[2:0];
      endcase
      if (is_short) begin
        q_nxt[j]    = PH_W'({kk, 2'b00}) + PH_W'({m3, {LG_LONG{1'b0}}});
        step_nxt[j] = PH_W'({kk, 3'b000});
      end else begin
        q_nxt[j]    = PH_W'({kk, 1'b0}) + PH_W'({m3, {LG_LONG{1'b0}}});
        step_nxt[j] = PH_W'({kk, 2'b00});
      end
    end
  end

  // Fold the phase onto the quarter-wave table.
  always_comb begin
    logic [PH_W:0] q;
    for (int j = 0; j < LANES; j++) begin
      q = {1'b0, q_r[j]};
      if (q <= Q1) begin
        caddr_nxt[j] = CADDR_W'(q);
        neg_nxt[j]   = 1'b0;
      end else if (q < Q2) begin
        caddr_nxt[j] = CADDR_W'(Q2 - q);
        neg_nxt[j]   = 1'b1;
      end else if (q <= Q3) begin
        caddr_nxt[j] = CADDR_W'(q - Q2);
        neg_nxt[j]   = 1'b1;
      end else begin
        caddr_nxt[j] = CADDR_W'(Q4 - q);
        neg_nxt[j]   = 1'b0;
      end
    end
  end

  always_comb begin
    case (sel1_r)
      2'd0:    smp2_nxt = row_r.sample_0;
      2'd1:    smp2_nxt = row_r.sample_1;
      2'd2:    smp2_nxt = row_r.sample_2;
      default: smp2_nxt = row_r.sample_3;
    endcase
  end

  always_comb begin
    logic signed [COS_W-1:0] c;
    for (int j = 0; j < LANES; j++) begin
      c = $signed({1'b0, cdat[j]});
      if (neg2_r[j]) c = -c;
      prod3_nxt[j] = PROD_W'(smp2_r * c);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) store_mem[cmd.wr_row] <= in_data;
    if (cmd.issue) row_r <= store_mem[cmd.n[N_W-1:2]];
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < LANES; j++) begin
      if (cmd.grp_init) begin
        q_r[j]    <= q_nxt[j];
        step_r[j] <= step_nxt[j];
      end else if (cmd.issue) begin
        q_r[j] <= q_r[j] + step_r[j];
      end
      caddr1_r[j] <= caddr_nxt[j];
      neg1_r[j]   <= neg_nxt[j];
      neg2_r[j]   <= neg1_r[j];
      prod3_r[j]  <= prod3_nxt[j];
      if (cmd.grp_init) acc_r[j] <= '0;
      else if (v3_r) acc_r[j] <= acc_r[j] + ACC_W'(prod3_r[j]);
    end
    sel1_r <= cmd.n[1:0];
    smp2_r <= smp2_nxt;
  end

  mfbs_cos_rom u_rom_lo (
    .clk    (clk),
    .addr_a (caddr1_r[0]),
    .addr_b (caddr1_r[1]),
    .data_a (cdat[0]),
    .data_b (cdat[1])
  );

  mfbs_cos_rom u_rom_hi (
    .clk    (clk),
    .addr_a (caddr1_r[2]),
    .addr_b (caddr1_r[3]),
    .data_a (cdat[2]),
    .data_b (cdat[3])
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r <= cmd.issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (cmd.load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign short_r = is_short;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r.coef_0     <= finish_coef(acc_r[0], short_r);
      out_data_r.coef_1     <= finish_coef(acc_r[1], short_r);
      out_data_r.coef_2     <= finish_coef(acc_r[2], short_r);
      out_data_r.coef_3     <= finish_coef(acc_r[3], short_r);
      out_data_r.coef_index <= {cmd.grp, 2'b00};
      out_data_r.block_done <= cmd.last_grp;
    end
  end

  assign sts.pipe_busy = v1_r | v2_r | v3_r;
  assign sts.out_free  = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

endmodule
`default_nettype wire

/* src/mfbs_ctrl.sv */
// Controller: mode register, transaction count, group and sample sequencing.
`default_nettype none
module mfbs_ctrl
  import mfbs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_wdata,
  input  wire mfbs_sts_t  sts,
  output mfbs_cmd_t       cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [1:0]       mode_r;
  logic [ROW_W-1:0] items_r, items_nxt;
  logic [N_W-1:0]   n_r, n_nxt;
  logic [GRP_W-1:0] grp_r, grp_nxt;
  logic             is_short;
  logic [ROW_W-1:0] items_last;
  logic [N_W-1:0]   n_last;
  logic [GRP_W-1:0] grp_last;
  logic             in_fire;
  // next group's phases load once the current group has left the accumulators
  logic             grp_init_r, grp_init_nxt;

  assign is_short   = mode_r inside {MODE_SHORT1, MODE_SHORT2};
  assign items_last = is_short ? ROW_W'(ROWS / 2 - 1) : ROW_W'(ROWS - 1);
  assign n_last     = is_short ? N_W'(LONG_LEN / 2 - 1) : N_W'(LONG_LEN - 1);
  assign grp_last   = is_short ? GRP_W'(LONG_LEN / 16 - 1) : GRP_W'(LONG_LEN / 8 - 1);
  assign in_ready   = (state_r == ST_IDLE);
  assign in_fire    = in_valid && in_ready;

  always_comb begin
    state_nxt    = state_r;
    items_nxt    = items_r;
    n_nxt        = n_r;
    grp_nxt      = grp_r;
    grp_init_nxt = 1'b0;
    cmd          = '0;
    cmd.mode     = mode_r;
    cmd.wr_row   = items_r;
    cmd.n        = n_r;
    cmd.grp      = grp_r;
    cmd.last_grp = (grp_r == grp_last);
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.wr_en = 1'b1;
          if (items_r >= items_last) begin
            items_nxt    = '0;
            grp_nxt      = '0;
            n_nxt        = '0;
            cmd.grp      = '0;
            cmd.grp_init = 1'b1;
            state_nxt    = ST_RUN;
          end else begin
            items_nxt = items_r + ROW_W'(1);
          end
        end
      end
      ST_RUN: begin
        if (grp_init_r) begin
          cmd.grp_init = 1'b1;
        end else begin
          cmd.issue = 1'b1;
          if (n_r == n_last) state_nxt = ST_FLUSH;
          else n_nxt = n_r + N_W'(1);
        end
      end
      ST_FLUSH: begin
        if (!sts.pipe_busy) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          if (grp_r == grp_last) begin
            state_nxt = ST_IDLE;
          end else begin
            grp_nxt      = grp_r + GRP_W'(1);
            n_nxt        = '0;
            grp_init_nxt = 1'b1;
            state_nxt    = ST_RUN;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      mode_r     <= MODE_LONG;
      items_r    <= '0;
      n_r        <= '0;
      grp_r      <= '0;
      grp_init_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      items_r    <= items_nxt;
      n_r        <= n_nxt;
      grp_r      <= grp_nxt;
      grp_init_r <= grp_init_nxt;
      if (cfg_we) mode_r <= cfg_wdata;
    end
  end

endmodule
`default_nettype wire

/* src/mdct_forward_block_switched_core.sv */
// Top level of the block-switched forward MDCT core.
// Usage:
//   Input channel in_valid/in_ready/in_data moves four windowed Q1.23 samples per
//   transaction. A long block takes 128 transactions, a short block 64; cfg_wdata
//   written with cfg_we selects long (0), first short (1) or second short (2).
//   Transactions are taken one per cycle while the core is idle. The last one of
//   a block starts the transform; in_ready stays low until the last result is in
//   the output register.
//   Output channel out_valid/out_ready/out_data moves four coefficients per
//   transaction with coef_index and block_done, 64 results for long, 32 for short.
//   Each group of four coefficients takes a phase load, then all stored samples
//   through the four MAC lanes (one stored sample per cycle), then pipeline drain
//   and hand-off.
//   A stalled receiver holds the core in its hand-off step; nothing is dropped.
//   Reset (rst_n low, synchronous) clears the control state and selects long
//   mode; stored samples are undefined until written.
`default_nettype none
module mdct_forward_block_switched_core
  import mfbs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_item_t       out_data,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_wdata
);

  mfbs_cmd_t cmd;
  mfbs_sts_t sts;

  mfbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sts       (sts),
    .cmd       (cmd)
  );

  mfbs_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_ready (out_ready),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // no input is taken while a group is in the MAC pipeline
  a_busy_no_input: assert property (@(posedge clk) disable iff (!rst_n)
    sts.pipe_busy |-> !in_ready)
    else $error("input accepted while MAC pipeline busy");

  // after the last group of a block leaves, nothing follows until a new block
  a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.block_done |=> !out_valid)
    else $error("result after end of block");

  // results are only loaded once the pipeline has drained
  a_load_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !sts.pipe_busy && !cmd.issue)
    else $error("result loaded while MAC pipeline busy");
`endif

endmodule
`default_nettype wire
